FILE: sv/tle_pkg.sv
// Shared types, constants and helper functions of the terminal line editor.
package tle_pkg;

    localparam int LINE_CHARS = 32;
    localparam int HIST_DEPTH = 8;

    localparam int LEN_W   = $clog2(LINE_CHARS + 1);
    localparam int LIDX_W  = $clog2(LINE_CHARS);
    localparam int HIDX_W  = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
    localparam int HADDR_W = HIDX_W + LIDX_W;
    localparam int ROM_W   = 5;

    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_ESC   = 8'h1B;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TILDE = 8'h7E;
    localparam logic [7:0] CH_DEL   = 8'h7F;
    localparam logic [7:0] CH_LBRK  = 8'h5B;
    localparam logic [7:0] CH_THREE = 8'h33;
    localparam logic [7:0] CH_UP    = 8'h41;
    localparam logic [7:0] CH_DOWN  = 8'h42;
    localparam logic [7:0] CH_RIGHT = 8'h43;
    localparam logic [7:0] CH_LEFT  = 8'h44;

    // Echo string ROM layout: cursor left, save+clear, restore, cursor right, prompt.
    localparam logic [ROM_W-1:0] SEG_LEFT_BEG    = 5'd0;
    localparam logic [ROM_W-1:0] SEG_LEFT_END    = 5'd2;
    localparam logic [ROM_W-1:0] SEG_SAVE_BEG    = 5'd3;
    localparam logic [ROM_W-1:0] SEG_SAVE_END    = 5'd7;
    localparam logic [ROM_W-1:0] SEG_RESTORE_BEG = 5'd8;
    localparam logic [ROM_W-1:0] SEG_RESTORE_END = 5'd9;
    localparam logic [ROM_W-1:0] SEG_RIGHT_BEG   = 5'd10;
    localparam logic [ROM_W-1:0] SEG_RIGHT_END   = 5'd12;
    localparam logic [ROM_W-1:0] SEG_PROMPT_BEG  = 5'd13;
    localparam logic [ROM_W-1:0] SEG_PROMPT_END  = 5'd22;

    typedef enum logic [1:0] {
        ESC_IDLE,
        ESC_GOT_ESC,
        ESC_GOT_BRACKET,
        ESC_GOT_THREE
    } t_esc;

    typedef enum logic [3:0] {
        CLS_NOP,
        CLS_RIGHT,
        CLS_LEFT,
        CLS_UP,
        CLS_DOWN,
        CLS_DEL,
        CLS_BKSP,
        CLS_INS,
        CLS_CR
    } t_cls;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_ACCEPT,
        OP_RM_RD,
        OP_RM_WR,
        OP_RM_END,
        OP_INS_RD,
        OP_INS_WR,
        OP_INS_PUT,
        OP_SEG_EMIT,
        OP_TAIL_RD,
        OP_TAIL_EMIT,
        OP_CUR_INC,
        OP_REC_RD,
        OP_REC_EMIT,
        OP_TRIM_RD,
        OP_TRIM_CHK,
        OP_IDX_ZERO,
        OP_CMP_RD,
        OP_CMP_CHK,
        OP_PUSH,
        OP_NL_EMIT,
        OP_CR_RD,
        OP_CR_EMIT,
        OP_CR_END
    } t_dp_op;

    typedef enum logic [4:0] {
        S_IDLE,
        S_RM_CHK,
        S_RM_LOOP,
        S_RM_RD,
        S_RM_WR,
        S_INS_LOOP,
        S_INS_RD,
        S_INS_WR,
        S_SEG_PRE,
        S_TAIL_RD,
        S_TAIL_EMIT,
        S_SEG_POST,
        S_REC_RD,
        S_REC_EMIT,
        S_TRIM_RD,
        S_TRIM_CHK,
        S_CR_DECIDE,
        S_CMP_RD,
        S_CMP_CHK,
        S_CR_PUSH,
        S_CR_NL,
        S_CR_RD,
        S_CR_EMIT,
        S_CR_END
    } t_state;

    typedef struct packed {
        t_dp_op           op;
        logic             seg_load;
        logic [ROM_W-1:0] seg_beg;
        logic [ROM_W-1:0] seg_end;
        logic             seg_last;
    } t_dp_cmd;

    typedef struct packed {
        t_cls cls;
        logic rm_need;
        logic rm_more;
        logic ins_more;
        logic idx_lt_len;
        logic idx_last;
        logic len_zero;
        logic space;
        logic hist_match;
        logic cmp_eq;
        logic seg_end;
        logic out_free;
    } t_dp_status;

    function automatic logic [7:0] echo_rom(input logic [ROM_W-1:0] addr);
        logic [7:0] b;
        case (addr)
            5'd0:    b = 8'h1B;
            5'd1:    b = 8'h5B;
            5'd2:    b = 8'h44;
            5'd3:    b = 8'h1B;
            5'd4:    b = 8'h37;
            5'd5:    b = 8'h1B;
            5'd6:    b = 8'h5B;
            5'd7:    b = 8'h4B;
            5'd8:    b = 8'h1B;
            5'd9:    b = 8'h38;
            5'd10:   b = 8'h1B;
            5'd11:   b = 8'h5B;
            5'd12:   b = 8'h43;
            5'd13:   b = 8'h1B;
            5'd14:   b = 8'h5B;
            5'd15:   b = 8'h32;
            5'd16:   b = 8'h4B;
            5'd17:   b = 8'h0D;
            5'd18:   b = 8'h5A;
            5'd19:   b = 8'h31;
            5'd20:   b = 8'h20;
            5'd21:   b = 8'h3E;
            5'd22:   b = 8'h20;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    // Physical history slot of logical entry k (0 is newest).
    function automatic logic [HIDX_W-1:0] hist_slot(input logic [HIDX_W-1:0] head,
                                                    input logic [HIDX_W-1:0] k);
        logic [HIDX_W:0] sum;
        sum = {1'b0, head} + {1'b0, k};
        if (sum >= (HIDX_W+1)'(HIST_DEPTH)) begin
            sum = sum - (HIDX_W+1)'(HIST_DEPTH);
        end
        return sum[HIDX_W-1:0];
    endfunction

endpackage

FILE: sv/tle_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: sv/tle_dp.sv
// Datapath: line and history stores, editor registers, echo ROM and output register.
module tle_dp import tle_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [7:0] i_rx_char,
    input  t_dp_cmd    i_cmd,
    output t_dp_status o_status,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_out_byte,
    output logic       o_byte_kind,
    output logic       o_line_done,
    output logic       o_last_of_run
);

    logic [LEN_W-1:0]  r_len;
    logic [LEN_W-1:0]  r_cursor;
    t_esc              r_esc;
    logic              r_rec_valid;
    logic [HIDX_W-1:0] r_rec_idx;
    logic [HIDX_W-1:0] r_head;
    logic [HIDX_W-1:0] r_slot;
    logic [LEN_W-1:0]  r_hist_len [HIST_DEPTH];
    logic              r_push;
    logic [LEN_W-1:0]  r_idx;
    logic [7:0]        r_char;
    logic [ROM_W-1:0]  r_ptr;
    logic [ROM_W-1:0]  r_seg_end;
    logic              r_seg_last;
    logic              r_out_valid;
    logic [7:0]        r_out_byte;
    logic              r_out_kind;
    logic              r_out_done;
    logic              r_out_last;

    logic [7:0]        line_rd;
    logic [7:0]        hist_rd;
    logic              line_we;
    logic [LIDX_W-1:0] line_waddr;
    logic [7:0]        line_wdata;
    logic              line_re;
    logic [LIDX_W-1:0] line_raddr;
    logic              hist_we;
    logic              hist_re;
    logic [HADDR_W-1:0] hist_raddr;

    t_cls              cls;
    t_esc              esc_next;
    logic [LEN_W-1:0]  new_len;
    logic [HIDX_W:0]   up_k;
    logic [HIDX_W-1:0] up_slot;
    logic [HIDX_W-1:0] down_slot;
    logic [HIDX_W-1:0] tgt_idx;
    logic [HIDX_W-1:0] tgt_slot;
    logic              up_ok;
    logic              down_ok;
    logic              printable;
    logic [HIDX_W-1:0] new_head;
    logic [LEN_W:0]    idx_p1;
    logic              out_free;
    logic              emit;
    logic [7:0]        emit_byte;
    logic              emit_kind;
    logic              emit_last;
    logic              emit_done;

    assign out_free = !r_out_valid || !i_out_stall;
    assign idx_p1   = {1'b0, r_idx} + (LEN_W+1)'(1);
    assign new_head = (r_head == '0) ? HIDX_W'(HIST_DEPTH - 1) : r_head - HIDX_W'(1);

    // Classify the incoming character against the current editor state.
    always_comb begin
        printable = (i_rx_char >= CH_SPACE) && (i_rx_char <= CH_TILDE);
        new_len   = (r_len < LEN_W'(LINE_CHARS)) ? r_len + LEN_W'(1) : r_len;
        up_k      = r_rec_valid ? {1'b0, r_rec_idx} + (HIDX_W+1)'(1) : '0;
        up_slot   = hist_slot(r_head, up_k[HIDX_W-1:0]);
        down_slot = hist_slot(r_head, r_rec_idx - HIDX_W'(1));
        up_ok     = (!r_rec_valid || ({1'b0, r_rec_idx} < (HIDX_W+1)'(HIST_DEPTH - 1)))
                    && (r_hist_len[up_slot] != '0);
        down_ok   = r_rec_valid && (r_rec_idx != '0) && (r_hist_len[down_slot] != '0);

        esc_next = ESC_IDLE;
        if (i_rx_char == CH_ESC) begin
            esc_next = ESC_GOT_ESC;
        end else if (r_esc == ESC_GOT_ESC && i_rx_char == CH_LBRK) begin
            esc_next = ESC_GOT_BRACKET;
        end else if (r_esc == ESC_GOT_BRACKET && i_rx_char == CH_THREE) begin
            esc_next = ESC_GOT_THREE;
        end

        cls = CLS_NOP;
        if (i_rx_char == CH_ESC) begin
            cls = CLS_NOP;
        end else if (r_esc == ESC_GOT_ESC && i_rx_char == CH_LBRK) begin
            cls = CLS_NOP;
        end else if (r_esc == ESC_GOT_BRACKET && i_rx_char == CH_THREE) begin
            cls = CLS_NOP;
        end else if (r_esc == ESC_GOT_THREE && i_rx_char == CH_TILDE) begin
            cls = CLS_DEL;
        end else if (r_esc == ESC_GOT_BRACKET && i_rx_char == CH_RIGHT) begin
            cls = (r_cursor < r_len) ? CLS_RIGHT : CLS_NOP;
        end else if (r_esc == ESC_GOT_BRACKET && i_rx_char == CH_LEFT) begin
            cls = (r_cursor != '0) ? CLS_LEFT : CLS_NOP;
        end else if (r_esc == ESC_GOT_BRACKET && i_rx_char == CH_UP) begin
            cls = up_ok ? CLS_UP : CLS_NOP;
        end else if (r_esc == ESC_GOT_BRACKET && i_rx_char == CH_DOWN) begin
            cls = down_ok ? CLS_DOWN : CLS_NOP;
        end else if ((i_rx_char == CH_BS || i_rx_char == CH_DEL) && r_cursor != '0
                     && r_esc == ESC_IDLE) begin
            cls = CLS_BKSP;
        end else if (printable && r_cursor < LEN_W'(LINE_CHARS) && r_esc == ESC_IDLE) begin
            cls = CLS_INS;
        end else if (i_rx_char == CH_CR) begin
            cls = CLS_CR;
        end

        tgt_idx  = (cls == CLS_UP) ? up_k[HIDX_W-1:0] : r_rec_idx - HIDX_W'(1);
        tgt_slot = (cls == CLS_UP) ? up_slot : down_slot;
    end

    // Output byte selection.
    always_comb begin
        emit      = 1'b0;
        emit_byte = echo_rom(r_ptr);
        emit_kind = 1'b0;
        emit_last = 1'b0;
        emit_done = 1'b0;
        case (i_cmd.op)
            OP_SEG_EMIT: begin
                emit      = out_free;
                emit_last = r_seg_last && (r_ptr == r_seg_end);
            end
            OP_TAIL_EMIT: begin
                emit      = out_free;
                emit_byte = line_rd;
            end
            OP_REC_EMIT: begin
                emit      = out_free;
                emit_byte = hist_rd;
                emit_last = o_status.idx_last;
            end
            OP_NL_EMIT: begin
                emit      = out_free;
                emit_byte = CH_LF;
                emit_last = (r_len == '0);
                emit_done = (r_len == '0);
            end
            OP_CR_EMIT: begin
                emit      = out_free;
                emit_byte = line_rd;
                emit_kind = 1'b1;
                emit_last = o_status.idx_last;
                emit_done = o_status.idx_last;
            end
            default: ;
        endcase
    end

    // Memory port control.
    always_comb begin
        line_we    = 1'b0;
        line_waddr = r_idx[LIDX_W-1:0];
        line_wdata = line_rd;
        line_re    = 1'b0;
        line_raddr = r_idx[LIDX_W-1:0];
        hist_we    = 1'b0;
        hist_re    = 1'b0;
        hist_raddr = {r_head, r_idx[LIDX_W-1:0]};
        case (i_cmd.op)
            OP_RM_RD: begin
                line_re    = 1'b1;
                line_raddr = idx_p1[LIDX_W-1:0];
            end
            OP_RM_WR:  line_we = 1'b1;
            OP_INS_RD: begin
                line_re    = 1'b1;
                line_raddr = LIDX_W'(r_idx - LEN_W'(1));
            end
            OP_INS_WR: line_we = 1'b1;
            OP_INS_PUT: begin
                line_we    = 1'b1;
                line_waddr = r_cursor[LIDX_W-1:0];
                line_wdata = r_char;
            end
            OP_TAIL_RD: line_re = 1'b1;
            OP_TRIM_RD: line_re = 1'b1;
            OP_CR_RD:   line_re = 1'b1;
            OP_REC_RD: begin
                hist_re    = 1'b1;
                hist_raddr = {r_slot, r_idx[LIDX_W-1:0]};
            end
            OP_REC_EMIT: begin
                line_we    = out_free;
                line_wdata = hist_rd;
            end
            OP_CMP_RD: begin
                line_re = 1'b1;
                hist_re = 1'b1;
            end
            OP_CR_EMIT: hist_we = out_free && r_push;
            default: ;
        endcase
    end

    tle_ram #(.WIDTH(8), .DEPTH(LINE_CHARS)) u_line_ram (
        .i_clk     (i_clk),
        .i_wr_en   (line_we),
        .i_wr_addr (line_waddr),
        .i_wr_data (line_wdata),
        .i_rd_en   (line_re),
        .i_rd_addr (line_raddr),
        .o_rd_data (line_rd)
    );

    tle_ram #(.WIDTH(8), .DEPTH(2 ** HADDR_W)) u_hist_ram (
        .i_clk     (i_clk),
        .i_wr_en   (hist_we),
        .i_wr_addr ({r_head, r_idx[LIDX_W-1:0]}),
        .i_wr_data (line_rd),
        .i_rd_en   (hist_re),
        .i_rd_addr (hist_raddr),
        .o_rd_data (hist_rd)
    );

    // Editor control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= '0;
            r_cursor    <= '0;
            r_esc       <= ESC_IDLE;
            r_rec_valid <= 1'b0;
            r_head      <= '0;
            r_push      <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < HIST_DEPTH; i++) begin
                r_hist_len[i] <= '0;
            end
        end else begin
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (i_cmd.op)
                OP_ACCEPT: begin
                    r_esc <= esc_next;
                    case (cls)
                        CLS_RIGHT: r_cursor <= r_cursor + LEN_W'(1);
                        CLS_LEFT:  r_cursor <= r_cursor - LEN_W'(1);
                        CLS_BKSP:  r_cursor <= r_cursor - LEN_W'(1);
                        CLS_UP, CLS_DOWN: begin
                            r_rec_valid <= 1'b1;
                            r_len       <= r_hist_len[tgt_slot];
                            r_cursor    <= r_hist_len[tgt_slot];
                        end
                        CLS_INS: r_len    <= new_len;
                        CLS_CR:  r_cursor <= '0;
                        default: ;
                    endcase
                end
                OP_RM_END:   r_len <= r_len - LEN_W'(1);
                OP_TRIM_CHK: begin
                    if (o_status.space) begin
                        r_len <= r_len - LEN_W'(1);
                    end
                end
                OP_IDX_ZERO: r_push <= 1'b0;
                OP_PUSH: begin
                    r_head               <= new_head;
                    r_hist_len[new_head] <= r_len;
                    r_push               <= 1'b1;
                end
                OP_CUR_INC: r_cursor <= r_cursor + LEN_W'(1);
                OP_CR_END: begin
                    r_len       <= '0;
                    r_rec_valid <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    // Working payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.seg_load) begin
            r_ptr      <= i_cmd.seg_beg;
            r_seg_end  <= i_cmd.seg_end;
            r_seg_last <= i_cmd.seg_last;
        end
        if (emit) begin
            r_out_byte <= emit_byte;
            r_out_kind <= emit_kind;
            r_out_last <= emit_last;
            r_out_done <= emit_done;
        end
        case (i_cmd.op)
            OP_ACCEPT: begin
                r_char <= i_rx_char;
                case (cls)
                    CLS_DEL:  r_idx <= r_cursor;
                    CLS_BKSP: r_idx <= r_cursor - LEN_W'(1);
                    CLS_INS:  r_idx <= new_len - LEN_W'(1);
                    CLS_CR:   r_idx <= r_len - LEN_W'(1);
                    CLS_UP, CLS_DOWN: begin
                        r_idx     <= '0;
                        r_rec_idx <= tgt_idx;
                        r_slot    <= tgt_slot;
                    end
                    default: ;
                endcase
            end
            OP_RM_WR:   r_idx <= r_idx + LEN_W'(1);
            OP_RM_END:  r_idx <= r_cursor;
            OP_INS_WR:  r_idx <= r_idx - LEN_W'(1);
            OP_INS_PUT: r_idx <= r_cursor;
            OP_SEG_EMIT: begin
                if (out_free) begin
                    r_ptr <= r_ptr + ROM_W'(1);
                end
            end
            OP_TAIL_EMIT, OP_REC_EMIT, OP_CR_EMIT: begin
                if (out_free) begin
                    r_idx <= r_idx + LEN_W'(1);
                end
            end
            OP_TRIM_CHK: begin
                if (o_status.space) begin
                    r_idx <= r_idx - LEN_W'(1);
                end
            end
            OP_IDX_ZERO: r_idx <= '0;
            OP_CMP_CHK:  r_idx <= r_idx + LEN_W'(1);
            OP_NL_EMIT: begin
                if (out_free) begin
                    r_idx <= '0;
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        o_status.cls        = cls;
        o_status.rm_need    = r_cursor < r_len;
        o_status.rm_more    = idx_p1 < {1'b0, r_len};
        o_status.ins_more   = r_idx > r_cursor;
        o_status.idx_lt_len = r_idx < r_len;
        o_status.idx_last   = idx_p1 == {1'b0, r_len};
        o_status.len_zero   = r_len == '0;
        o_status.space      = line_rd == CH_SPACE;
        o_status.hist_match = r_hist_len[r_head] == r_len;
        o_status.cmp_eq     = line_rd == hist_rd;
        o_status.seg_end    = r_ptr == r_seg_end;
        o_status.out_free   = out_free;
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_byte    = r_out_byte;
    assign o_byte_kind   = r_out_kind;
    assign o_line_done   = r_out_done;
    assign o_last_of_run = r_out_last;

endmodule

FILE: sv/tle_ctrl.sv
// Controller: sequences shift, redraw, recall and line-completion passes per character.
module tle_ctrl import tle_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;
    t_cls   r_cls;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cls   <= CLS_NOP;
        end else begin
            r_state <= n_state;
            if (r_state == S_IDLE && i_in_valid) begin
                r_cls <= i_status.cls;
            end
        end
    end

    always_comb begin
        n_state        = r_state;
        o_cmd.op       = OP_NONE;
        o_cmd.seg_load = 1'b0;
        o_cmd.seg_beg  = SEG_LEFT_BEG;
        o_cmd.seg_end  = SEG_LEFT_END;
        o_cmd.seg_last = 1'b0;
        o_in_stall     = (r_state != S_IDLE);
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = OP_ACCEPT;
                    case (i_status.cls)
                        CLS_RIGHT: begin
                            o_cmd.seg_load = 1'b1;
                            o_cmd.seg_beg  = SEG_RIGHT_BEG;
                            o_cmd.seg_end  = SEG_RIGHT_END;
                            o_cmd.seg_last = 1'b1;
                            n_state        = S_SEG_POST;
                        end
                        CLS_LEFT: begin
                            o_cmd.seg_load = 1'b1;
                            o_cmd.seg_last = 1'b1;
                            n_state        = S_SEG_POST;
                        end
                        CLS_UP, CLS_DOWN: begin
                            o_cmd.seg_load = 1'b1;
                            o_cmd.seg_beg  = SEG_PROMPT_BEG;
                            o_cmd.seg_end  = SEG_PROMPT_END;
                            n_state        = S_SEG_PRE;
                        end
                        CLS_DEL, CLS_BKSP: n_state = S_RM_CHK;
                        CLS_INS:           n_state = S_INS_LOOP;
                        CLS_CR:            n_state = S_TRIM_RD;
                        default:           n_state = S_IDLE;
                    endcase
                end
            end
            S_RM_CHK: begin
                if (i_status.rm_need) begin
                    n_state = S_RM_LOOP;
                end else begin
                    o_cmd.seg_load = 1'b1;
                    o_cmd.seg_beg  = SEG_SAVE_BEG;
                    o_cmd.seg_end  = SEG_SAVE_END;
                    n_state        = S_SEG_PRE;
                end
            end
            S_RM_LOOP: begin
                if (i_status.rm_more) begin
                    n_state = S_RM_RD;
                end else begin
                    o_cmd.op       = OP_RM_END;
                    o_cmd.seg_load = 1'b1;
                    o_cmd.seg_beg  = (r_cls == CLS_BKSP) ? SEG_LEFT_BEG : SEG_SAVE_BEG;
                    o_cmd.seg_end  = SEG_SAVE_END;
                    n_state        = S_SEG_PRE;
                end
            end
            S_RM_RD: begin
                o_cmd.op = OP_RM_RD;
                n_state  = S_RM_WR;
            end
            S_RM_WR: begin
                o_cmd.op = OP_RM_WR;
                n_state  = S_RM_LOOP;
            end
            S_INS_LOOP: begin
                if (i_status.ins_more) begin
                    n_state = S_INS_RD;
                end else begin
                    o_cmd.op       = OP_INS_PUT;
                    o_cmd.seg_load = 1'b1;
                    o_cmd.seg_beg  = SEG_SAVE_BEG;
                    o_cmd.seg_end  = SEG_SAVE_END;
                    n_state        = S_SEG_PRE;
                end
            end
            S_INS_RD: begin
                o_cmd.op = OP_INS_RD;
                n_state  = S_INS_WR;
            end
            S_INS_WR: begin
                o_cmd.op = OP_INS_WR;
                n_state  = S_INS_LOOP;
            end
            S_SEG_PRE: begin
                o_cmd.op = OP_SEG_EMIT;
                if (i_status.out_free && i_status.seg_end) begin
                    if (r_cls == CLS_UP || r_cls == CLS_DOWN) begin
                        n_state = S_REC_RD;
                    end else begin
                        n_state = S_TAIL_RD;
                    end
                end
            end
            S_TAIL_RD: begin
                if (i_status.idx_lt_len) begin
                    o_cmd.op = OP_TAIL_RD;
                    n_state  = S_TAIL_EMIT;
                end else begin
                    o_cmd.seg_load = 1'b1;
                    o_cmd.seg_beg  = SEG_RESTORE_BEG;
                    o_cmd.seg_last = 1'b1;
                    if (r_cls == CLS_INS) begin
                        o_cmd.op      = OP_CUR_INC;
                        o_cmd.seg_end = SEG_RIGHT_END;
                    end else begin
                        o_cmd.seg_end = SEG_RESTORE_END;
                    end
                    n_state = S_SEG_POST;
                end
            end
            S_TAIL_EMIT: begin
                o_cmd.op = OP_TAIL_EMIT;
                if (i_status.out_free) begin
                    n_state = S_TAIL_RD;
                end
            end
            S_SEG_POST: begin
                o_cmd.op = OP_SEG_EMIT;
                if (i_status.out_free && i_status.seg_end) begin
                    n_state = S_IDLE;
                end
            end
            S_REC_RD: begin
                o_cmd.op = OP_REC_RD;
                n_state  = S_REC_EMIT;
            end
            S_REC_EMIT: begin
                o_cmd.op = OP_REC_EMIT;
                if (i_status.out_free) begin
                    n_state = i_status.idx_last ? S_IDLE : S_REC_RD;
                end
            end
            S_TRIM_RD: begin
                if (i_status.len_zero) begin
                    n_state = S_CR_DECIDE;
                end else begin
                    o_cmd.op = OP_TRIM_RD;
                    n_state  = S_TRIM_CHK;
                end
            end
            S_TRIM_CHK: begin
                o_cmd.op = OP_TRIM_CHK;
                n_state  = i_status.space ? S_TRIM_RD : S_CR_DECIDE;
            end
            S_CR_DECIDE: begin
                o_cmd.op = OP_IDX_ZERO;
                if (i_status.len_zero) begin
                    n_state = S_CR_NL;
                end else if (i_status.hist_match) begin
                    n_state = S_CMP_RD;
                end else begin
                    n_state = S_CR_PUSH;
                end
            end
            S_CMP_RD: begin
                o_cmd.op = OP_CMP_RD;
                n_state  = S_CMP_CHK;
            end
            S_CMP_CHK: begin
                o_cmd.op = OP_CMP_CHK;
                if (!i_status.cmp_eq) begin
                    n_state = S_CR_PUSH;
                end else if (i_status.idx_last) begin
                    n_state = S_CR_NL;
                end else begin
                    n_state = S_CMP_RD;
                end
            end
            S_CR_PUSH: begin
                o_cmd.op = OP_PUSH;
                n_state  = S_CR_NL;
            end
            S_CR_NL: begin
                o_cmd.op = OP_NL_EMIT;
                if (i_status.out_free) begin
                    n_state = i_status.len_zero ? S_CR_END : S_CR_RD;
                end
            end
            S_CR_RD: begin
                o_cmd.op = OP_CR_RD;
                n_state  = S_CR_EMIT;
            end
            S_CR_EMIT: begin
                o_cmd.op = OP_CR_EMIT;
                if (i_status.out_free) begin
                    n_state = i_status.idx_last ? S_CR_END : S_CR_RD;
                end
            end
            S_CR_END: begin
                o_cmd.op = OP_CR_END;
                n_state  = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

FILE: sv/terminal_line_editor.sv
// Terminal line editor top level: one received character in, VT100 echo and line bytes out.
// A character with no echo is accepted without leaving idle; constant strings echo at one byte
// per cycle while the output is not stalled, and each line character takes a read state before
// its emit state, since it goes through a line or history RAM read port with registered data.
// An edit mid-line shifts the characters behind the cursor one by one, then redraws the tail;
// a carriage return runs compare and emit passes. Reset clears length, cursor, escape,
// recall state and history lengths; RAMs are not swept.
module terminal_line_editor import tle_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_rx_char,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_out_byte,
    output logic       o_byte_kind,
    output logic       o_line_done,
    output logic       o_last_of_run
);

    t_dp_cmd    cmd;
    t_dp_status status;

    tle_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    tle_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_rx_char     (i_rx_char),
        .i_cmd         (cmd),
        .o_status      (status),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_byte    (o_out_byte),
        .o_byte_kind   (o_byte_kind),
        .o_line_done   (o_line_done),
        .o_last_of_run (o_last_of_run)
    );

endmodule
